// ----- rtl/fcb_pkg.sv -----
// shared constants and types of the circular-buffer fir filter
package fcb_pkg;

  localparam int TAPS_DEF        = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_INDEX_BITS = 5;
  localparam int DIGIT_BITS      = 8;
  localparam int ACC_BITS        = 64;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_COEF   = 1'b1;

  typedef struct packed {
    logic clear;   // zero accumulator and product at item start
    logic accum;   // add finished product into accumulator
    logic step;    // consume one digit of the sample
    logic first;   // step works on the most significant digit
  } mac_ctrl_t;

endpackage

// ----- rtl/fcb_in_if.sv -----
// input channel: sample or coefficient-load items
interface fcb_in_if #(
  parameter int SAMPLE_BITS = fcb_pkg::SAMPLE_BITS_DEF
);
  import fcb_pkg::*;

  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [SAMPLE_BITS-1:0]     sample_in;
  logic        [COEF_INDEX_BITS-1:0] coef_index;
  logic signed [SAMPLE_BITS-1:0]     coef_value;

  modport source (output valid, action, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, action, sample_in, coef_index, coef_value, output ready);

endinterface

// ----- rtl/fcb_out_if.sv -----
// result channel: filtered samples
interface fcb_out_if #(
  parameter int SAMPLE_BITS = fcb_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);

endinterface

// ----- rtl/fcb_store.sv -----
// delay line and coefficient memories with per-entry valid bits
module fcb_store #(
  parameter int TAPS        = fcb_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fcb_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = $clog2(TAPS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          smp_we,
  input  logic [IDX_W-1:0]              smp_waddr,
  input  logic signed [SAMPLE_BITS-1:0] smp_wdata,
  input  logic                          coef_we,
  input  logic [IDX_W-1:0]              coef_waddr,
  input  logic signed [SAMPLE_BITS-1:0] coef_wdata,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              smp_raddr,
  input  logic [IDX_W-1:0]              coef_raddr,
  output logic signed [SAMPLE_BITS-1:0] smp_rdata,
  output logic signed [SAMPLE_BITS-1:0] coef_rdata
);
  import fcb_pkg::*;

  logic signed [SAMPLE_BITS-1:0] dmem [TAPS];
  logic signed [SAMPLE_BITS-1:0] cmem [TAPS];
  logic [TAPS-1:0]               dvld_r;
  logic [TAPS-1:0]               cvld_r;
  logic signed [SAMPLE_BITS-1:0] smp_rdata_r;
  logic signed [SAMPLE_BITS-1:0] coef_rdata_r;

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
      cvld_r <= '0;
    end else begin
      if (smp_we) begin
        dvld_r[smp_waddr] <= 1'b1;
      end
      if (coef_we) begin
        cvld_r[coef_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      dmem[smp_waddr] <= smp_wdata;
    end
    if (rd_en) begin
      smp_rdata_r <= dvld_r[smp_raddr] ? dmem[smp_raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      cmem[coef_waddr] <= coef_wdata;
    end
    if (rd_en) begin
      coef_rdata_r <= cvld_r[coef_raddr] ? cmem[coef_raddr] : '0;
    end
  end

  assign smp_rdata  = smp_rdata_r;
  assign coef_rdata = coef_rdata_r;

endmodule

// ----- rtl/fcb_mac.sv -----
// digit-serial multiply-accumulate with rounding and saturation
module fcb_mac #(
  parameter int SAMPLE_BITS = fcb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcb_pkg::mac_ctrl_t            ctrl,
  input  logic signed [SAMPLE_BITS-1:0] smp_rd,
  input  logic signed [SAMPLE_BITS-1:0] coef_rd,
  output logic signed [SAMPLE_BITS-1:0] y
);
  import fcb_pkg::*;

  localparam int NUM_DIGITS = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int SR_W       = NUM_DIGITS * DIGIT_BITS;
  localparam int PROD_W     = 2 * SAMPLE_BITS;
  localparam int PP_W       = SAMPLE_BITS + DIGIT_BITS + 1;
  localparam int SHIFT      = SAMPLE_BITS - 1;
  localparam int Q_W        = ACC_BITS - SHIFT + 1;

  localparam logic signed [Q_W-1:0] Y_MAX =
    {{(Q_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [Q_W-1:0] Y_MIN =
    {{(Q_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS - 1){1'b0}}};

  logic [SR_W-1:0]              sr_r, sr_nxt;
  logic signed [PROD_W-1:0]     prod_r, prod_nxt;
  logic signed [ACC_BITS-1:0]   acc_r, acc_nxt;

  logic signed [SR_W-1:0]       smp_ext;
  logic [SR_W-1:0]              src;
  logic [DIGIT_BITS-1:0]        dig;
  logic signed [DIGIT_BITS:0]   dig_s;
  logic signed [PP_W-1:0]       pp;
  logic signed [ACC_BITS-1:0]   prod_ext;
  logic signed [ACC_BITS-1:0]   sum;
  logic                         ovf;
  logic signed [Q_W-1:0]        q;

  // most significant digit first: it is signed, the rest are unsigned
  assign smp_ext = SR_W'(smp_rd);
  assign src     = ctrl.first ? smp_ext : sr_r;
  assign dig     = src[SR_W-1 -: DIGIT_BITS];
  assign dig_s   = $signed({ctrl.first ? dig[DIGIT_BITS-1] : 1'b0, dig});
  assign pp      = coef_rd * dig_s;

  always_comb begin
    sr_nxt   = sr_r;
    prod_nxt = prod_r;
    if (ctrl.clear) begin
      prod_nxt = '0;
    end else if (ctrl.step) begin
      sr_nxt   = src << DIGIT_BITS;
      prod_nxt = (ctrl.first ? PROD_W'(0) : (prod_r <<< DIGIT_BITS)) + PROD_W'(pp);
    end
  end

  // accumulation saturates at the accumulator limits
  assign prod_ext = ACC_BITS'(prod_r);
  assign sum      = acc_r + prod_ext;
  assign ovf      = (acc_r[ACC_BITS-1] == prod_ext[ACC_BITS-1])
                 && (sum[ACC_BITS-1] != acc_r[ACC_BITS-1]);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.accum) begin
      if (ovf) begin
        acc_nxt = acc_r[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  // round to nearest, ties toward plus infinity, then clamp
  assign q = Q_W'(acc_r >>> SHIFT) + $signed({{(Q_W - 1){1'b0}}, acc_r[SHIFT-1]});

  always_comb begin
    priority if (q > Y_MAX) begin
      y = Y_MAX[SAMPLE_BITS-1:0];
    end else if (q < Y_MIN) begin
      y = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y = q[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ----- rtl/fir_filter_circular_buffer_top.sv -----
// top level: sequencer, result register, store and mac
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        action, sample_in, coef_index, coef_value
//  out_ch   out  valid/ready        sample_out
//
// a coefficient load gives no item on out_ch.
// a sample item holds off the next accept until the sequencer is back in idle: for each
// tap one memory fetch plus one 8-bit sample digit per cycle through the shared
// multiplier, then accumulate and round.
// rst_n is synchronous; it clears the delay line and coefficients through valid bits.
// a full result register stalls the sequencer in its rounding step until taken.
module fir_filter_circular_buffer_top #(
  parameter int TAPS        = fcb_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = fcb_pkg::SAMPLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  fcb_in_if.sink   in_ch,
  fcb_out_if.source out_ch
);
  import fcb_pkg::*;

  localparam int IDX_W      = $clog2(TAPS);
  localparam int NUM_DIGITS = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [IDX_W-1:0] LAST_TAP   = IDX_W'(TAPS - 1);
  localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(NUM_DIGITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_SUM,
    S_ROUND
  } state_t;

  state_t                        state_r;
  logic [IDX_W-1:0]              wp_r;
  logic [IDX_W-1:0]              rd_ptr_r;
  logic [IDX_W-1:0]              tap_r;
  logic [DIG_W-1:0]              dig_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic                          accept;
  logic                          smp_we;
  logic                          coef_we;
  logic                          emit;
  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] smp_rd;
  logic signed [SAMPLE_BITS-1:0] coef_rd;
  logic signed [SAMPLE_BITS-1:0] mac_y;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign smp_we      = accept && (in_ch.action == ACT_SAMPLE);
  // a load beyond the last tap is dropped
  assign coef_we     = accept && (in_ch.action == ACT_COEF)
                    && (int'(in_ch.coef_index) < TAPS);
  assign emit        = (state_r == S_ROUND) && (!out_valid_r || out_ch.ready);

  always_comb begin
    mac_ctrl.clear = smp_we;
    mac_ctrl.accum = (state_r == S_FETCH) || (state_r == S_SUM);
    mac_ctrl.step  = (state_r == S_MUL);
    mac_ctrl.first = (dig_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (smp_we) begin
            rd_ptr_r <= wp_r;
            tap_r    <= '0;
            state_r  <= S_FETCH;
          end
        end
        S_FETCH: begin
          dig_r   <= '0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (dig_r == LAST_DIGIT) begin
            if (tap_r == LAST_TAP) begin
              state_r <= S_SUM;
            end else begin
              tap_r    <= tap_r + 1'b1;
              rd_ptr_r <= (rd_ptr_r == '0) ? LAST_TAP : rd_ptr_r - 1'b1;
              state_r  <= S_FETCH;
            end
          end else begin
            dig_r <= dig_r + 1'b1;
          end
        end
        S_SUM: begin
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (emit) begin
            out_data_r  <= mac_y;
            out_valid_r <= 1'b1;
            wp_r        <= (wp_r == LAST_TAP) ? '0 : wp_r + 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  fcb_store #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .smp_we     (smp_we),
    .smp_waddr  (wp_r),
    .smp_wdata  (in_ch.sample_in),
    .coef_we    (coef_we),
    .coef_waddr (IDX_W'(in_ch.coef_index)),
    .coef_wdata (in_ch.coef_value),
    .rd_en      (state_r == S_FETCH),
    .smp_raddr  (rd_ptr_r),
    .coef_raddr (tap_r),
    .smp_rdata  (smp_rd),
    .coef_rdata (coef_rd)
  );

  fcb_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .smp_rd  (smp_rd),
    .coef_rd (coef_rd),
    .y       (mac_y)
  );

  a_result_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_ROUND))
    else $error("result appeared outside the rounding step");

  a_round_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) && out_valid_r && !out_ch.ready |=> (state_r == S_ROUND))
    else $error("rounding step left while result register was full");

  a_pointer_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (wp_r != $past(wp_r)))
    else $error("write pointer did not advance with a result");

endmodule

// ----- tb/fcb_output_checker.sv -----
`timescale 1ns / 1ps
// checker that predicts the filter outputs from accepted items and compares them
module fcb_output_checker (
  input  logic clk,
  input  logic rst_n,
  fcb_in_if    in_ch,
  fcb_out_if   out_ch,
  output int   mismatches,
  output int   pending,
  output int   samples_seen,
  output int   loads_seen,
  output int   results_seen,
  output int   rail_hits
);
  import fcb_pkg::*;

  localparam int TAPS       = TAPS_DEF;
  localparam int SB         = SAMPLE_BITS_DEF;

  typedef logic signed [SB-1:0] sample_t;

  sample_t delay_hist [TAPS];
  sample_t coef_mem   [TAPS];
  int      wr_ptr;
  sample_t expected_outputs [$];

  int err_count, n_samples, n_loads, n_results, n_rails;

  // sum of coef[k] * delayed sample k, rounded half up to q1.15 and clipped
  function automatic sample_t filtered_sample();
    longint acc;
    longint y;
    longint hi;
    longint lo;
    hi  = (longint'(1) << (SB - 1)) - 1;
    lo  = -hi - 1;
    acc = 0;
    for (int tap = 0; tap < TAPS; tap++) begin
      acc += longint'(coef_mem[tap]) * longint'(delay_hist[(wr_ptr + TAPS - tap) % TAPS]);
    end
    y = (acc >>> (SB - 1)) + longint'(acc[SB-2]);
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    return sample_t'(y);
  endfunction

  task automatic report_mismatch(input string what, input sample_t want, input sample_t got);
    err_count++;
    $display("%0t: %s at output %0d: expected %0d got %0d", $time, what, n_results, want,
             got);
  endtask

  always @(posedge clk) begin : watch
    sample_t want;
    if (!rst_n) begin
      for (int tap = 0; tap < TAPS; tap++) begin
        delay_hist[tap] = '0;
        coef_mem[tap]   = '0;
      end
      wr_ptr = 0;
      expected_outputs.delete();
      err_count = 0;
      n_samples = 0;
      n_loads   = 0;
      n_results = 0;
      n_rails   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_outputs.size() == 0) begin
          report_mismatch("output with none expected", '0, out_ch.sample_out);
        end else begin
          want = expected_outputs.pop_front();
          if (out_ch.sample_out !== want) report_mismatch("sample_out wrong", want,
                                                          out_ch.sample_out);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_COEF) begin
          n_loads++;
          if (int'(in_ch.coef_index) < TAPS) coef_mem[in_ch.coef_index] = in_ch.coef_value;
        end else begin
          n_samples++;
          delay_hist[wr_ptr] = in_ch.sample_in;
          want = filtered_sample();
          expected_outputs.push_back(want);
          if (want == {1'b0, {(SB-1){1'b1}}} || want == {1'b1, {(SB-1){1'b0}}}) n_rails++;
          wr_ptr = (wr_ptr + 1) % TAPS;
        end
      end
    end
    mismatches   <= err_count;
    pending      <= expected_outputs.size();
    samples_seen <= n_samples;
    loads_seen   <= n_loads;
    results_seen <= n_results;
    rail_hits    <= n_rails;
  end

endmodule

// ----- tb/tb_fir_filter_circular_buffer_top.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, item stimulus, output receiver and verdict
module tb_fir_filter_circular_buffer_top;
  import fcb_pkg::*;

  localparam int SB             = SAMPLE_BITS_DEF;
  localparam int TAPS           = TAPS_DEF;
  localparam int RANDOM_ITEMS   = 1625;
  localparam int IDLE_PCT       = 16;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = TAPS * (1 + (SB + 7) / 8) + 3 + 20;

  typedef logic signed [SB-1:0] sample_t;

  localparam sample_t MAX_VAL = {1'b0, {(SB-1){1'b1}}};
  localparam sample_t MIN_VAL = {1'b1, {(SB-1){1'b0}}};

  logic clk;
  logic rst_n;
  logic idle_on;
  logic stall_req;
  logic stall_served;
  int   hold_left;
  int   quiet_cycles;

  int mismatches, pending, samples_seen, loads_seen, results_seen, rail_hits;

  fcb_in_if  in_ch ();
  fcb_out_if out_ch ();

  fir_filter_circular_buffer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fcb_output_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .samples_seen (samples_seen),
    .loads_seen   (loads_seen),
    .results_seen (results_seen),
    .rail_hits    (rail_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mix of rails, zero, full-range and scaled-down values
  function automatic sample_t shaped_value();
    sample_t v;
    int      pick;
    v    = sample_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) v = MIN_VAL;
    else if (pick < 16) v = MAX_VAL;
    else if (pick < 22) v = '0;
    else if (pick < 60) v = v >>> $urandom_range(1, SB - 2);
    return v;
  endfunction

  task automatic send_item(input logic act, input sample_t smp,
                           input logic [COEF_INDEX_BITS-1:0] idx, input sample_t val);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.sample_in  <= smp;
    in_ch.coef_index <= idx;
    in_ch.coef_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_sample(input sample_t smp);
    send_item(ACT_SAMPLE, smp, COEF_INDEX_BITS'($urandom), sample_t'($urandom));
  endtask

  task automatic send_coef(input logic [COEF_INDEX_BITS-1:0] idx, input sample_t val);
    send_item(ACT_COEF, sample_t'($urandom), idx, val);
  endtask

  // receiver: random back-pressure plus one long hold-off
  initial begin : receiver
    out_ch.ready = 1'b0;
    stall_served = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (stall_req && !stall_served) begin
        stall_served = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int n_loads;
    int run;
    rst_n            = 1'b0;
    idle_on          = 1'b1;
    stall_req        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_SAMPLE;
    in_ch.sample_in  = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero coefficients give zero out
    send_sample(MAX_VAL);
    // -1 * -1 overflows q1.15 and clips high
    send_coef(COEF_INDEX_BITS'(0), MIN_VAL);
    send_sample(MIN_VAL);
    // two large opposite products clip low
    send_coef(COEF_INDEX_BITS'(1), MAX_VAL);
    send_sample(MAX_VAL);
    // half-lsb ties round toward plus infinity on both signs
    send_coef(COEF_INDEX_BITS'(0), sample_t'(1 << (SB - 2)));
    send_coef(COEF_INDEX_BITS'(1), '0);
    send_sample(sample_t'(1));
    send_sample(sample_t'(-1));
    // last tap and an all-ones coefficient
    send_coef(COEF_INDEX_BITS'(TAPS - 1), MAX_VAL);
    send_coef(COEF_INDEX_BITS'(0), sample_t'(-1));
    send_sample('0);
    send_sample(MIN_VAL);
    send_sample(MAX_VAL);

    // bursts: reprogram up to six random taps or all taps, then a run of samples through them
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      stall_req <= (sent >= 300);
      idle_on   <= !(sent >= 800 && sent < 1100);
      if ($urandom_range(99) < 5) begin
        for (int tap = 0; tap < TAPS; tap++) begin
          send_coef(COEF_INDEX_BITS'(tap), shaped_value());
          sent++;
        end
      end else begin
        n_loads = $urandom_range(0, 6);
        for (int i = 0; i < n_loads; i++) begin
          send_coef(COEF_INDEX_BITS'($urandom_range(0, TAPS - 1)), shaped_value());
          sent++;
        end
      end
      run = $urandom_range(4, 30);
      for (int i = 0; i < run; i++) begin
        send_sample(shaped_value());
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d sample items and %0d coefficient loads, %0d outputs checked",
             samples_seen, loads_seen, results_seen);
    $display("%0d outputs at a saturation rail; one %0d-cycle output hold-off filled the block",
             rail_hits, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fcb_pkg.sv
rtl/fcb_in_if.sv
rtl/fcb_out_if.sv
rtl/fcb_store.sv
rtl/fcb_mac.sv
rtl/fir_filter_circular_buffer_top.sv
tb/fcb_output_checker.sv
tb/tb_fir_filter_circular_buffer_top.sv
